// ===== src/dmp_pkg.sv =====
// shared types, constants and codes for the device memory placement core
`default_nettype none

package dmp_pkg;

	// field widths fixed by the transaction format
	localparam int CMD_W     = 2;
	localparam int BACKEND_W = 2;
	localparam int DEV_W     = 4;
	localparam int AMOUNT_W  = 40;
	localparam int JOB_W     = 8;
	localparam int STATUS_W  = 2;

	// default sizing of the core
	localparam int MAX_DEVICES_DEF  = 16;
	localparam int NUM_BACKENDS_DEF = 4;
	localparam int MEM_BITS_DEF     = 40;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PLACE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_DEVICE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// request transaction
	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [BACKEND_W-1:0] backend;
		logic [DEV_W-1:0]     device_id;
		logic [AMOUNT_W-1:0]  amount;
		logic [JOB_W-1:0]     job_id;
	} req_t;

	// response transaction
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DEV_W-1:0]    placed_device;
		logic [JOB_W-1:0]    placed_job;
		logic [AMOUNT_W-1:0] remaining;
	} rsp_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_LOAD,
		S_INSERT,
		S_TRY,
		S_SORT,
		S_TOP,
		S_WRITE,
		S_RESP
	} dmp_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic decode;
		logic load_step;
		logic insert;
		logic try_place;
		logic sort_step;
		logic top_place;
		logic write_step;
		logic respond;
	} dmp_ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_add;
		logic is_place;
		logic add_reject;
		logic place_reject;
		logic load_done;
		logic sort_done;
		logic write_done;
		logic fit;
		logic pos_last;
		logic placed;
		logic out_free;
	} dmp_sts_t;

endpackage

`default_nettype wire

// ===== src/dmp_datapath.sv =====
// datapath: device table memory, working list, sorter, placement arithmetic
`default_nettype none

module dmp_datapath #(
	parameter int MAX_DEVICES  = dmp_pkg::MAX_DEVICES_DEF,
	parameter int NUM_BACKENDS = dmp_pkg::NUM_BACKENDS_DEF,
	parameter int MEM_BITS     = dmp_pkg::MEM_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dmp_pkg::req_t      req,
	output dmp_pkg::rsp_t      rsp,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	input  dmp_pkg::dmp_ctl_t  ctl,
	output dmp_pkg::dmp_sts_t  sts
);
	import dmp_pkg::*;

	localparam int CW    = $clog2(MAX_DEVICES + 1);
	localparam int PW    = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int BW    = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;
	localparam int DEPTH = NUM_BACKENDS * MAX_DEVICES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AMW   = (MEM_BITS > AMOUNT_W) ? MEM_BITS : AMOUNT_W;
	localparam int BXW   = (BW > BACKEND_W) ? BW : BACKEND_W;

	typedef struct packed {
		logic [DEV_W-1:0]    dev;
		logic [MEM_BITS-1:0] free;
	} entry_t;

	// list order: more free memory first, lower device number on a tie
	function automatic logic goes_before(entry_t a, entry_t b);
		goes_before = (a.free > b.free) || ((a.free == b.free) && (a.dev < b.dev));
	endfunction

	// captured transaction
	logic [CMD_W-1:0]    cmd_q;
	logic [BW-1:0]       bidx_q;
	logic                bok_q;
	logic [DEV_W-1:0]    dev_q;
	logic [MEM_BITS-1:0] amt_q;
	logic [JOB_W-1:0]    job_q;

	// per backend bookkeeping
	logic [CW-1:0] cnt_q [NUM_BACKENDS];
	logic [PW-1:0] rot_q [NUM_BACKENDS];

	// sequencing
	logic [CW-1:0] idx_q;
	logic [CW-1:0] len_q;
	logic          placed_q;
	logic          out_valid_q;

	// working list, one lane per list position
	entry_t work_q    [MAX_DEVICES];
	entry_t sort_next [MAX_DEVICES];
	entry_t ins_next  [MAX_DEVICES];

	// table memory
	entry_t        mem [DEPTH];
	entry_t        rdata_q;
	logic [AW-1:0] maddr;

	// result
	logic [STATUS_W-1:0] res_status_q;
	logic [DEV_W-1:0]    res_dev_q;
	logic [MEM_BITS-1:0] res_rem_q;
	rsp_t                out_q;

	logic [AMW-1:0]      amt_wide;
	logic [BXW-1:0]      bsel_wide;
	logic [AMW-1:0]      rem_wide;
	logic [CW-1:0]       n;
	logic [CW-1:0]       n_m1;
	logic [CW-1:0]       len_m1;
	logic [PW-1:0]       rot_cur;
	logic [PW-1:0]       pos_eff;
	logic [CW-1:0]       lidx;
	logic [PW-1:0]       lane;
	entry_t              sel;
	entry_t              top_e;
	entry_t              new_e;
	logic                fit;
	logic                top_fit;
	logic [MEM_BITS-1:0] sel_diff;
	logic [MEM_BITS-1:0] top_diff;
	logic [CW-1:0]       ins_pos;
	logic                add_reject;
	logic                place_reject;
	logic                sort_done;
	logic                pos_last;

	// field resizing
	assign amt_wide  = AMW'(req.amount);
	assign bsel_wide = BXW'(req.backend);
	assign rem_wide  = AMW'(res_rem_q);

	// list of the current backend
	assign n       = bok_q ? cnt_q[bidx_q] : '0;
	assign n_m1    = n - CW'(1);
	assign len_m1  = len_q - CW'(1);
	assign rot_cur = bok_q ? rot_q[bidx_q] : '0;
	assign pos_eff = (CW'(rot_cur) >= n) ? '0 : rot_cur;
	assign lidx    = idx_q - CW'(1);
	assign lane    = lidx[PW-1:0];
	assign maddr   = AW'(32'(bidx_q) * MAX_DEVICES + 32'(idx_q));

	// placement compare and subtract
	assign sel      = work_q[pos_eff];
	assign fit      = sel.free >= amt_q;
	assign sel_diff = sel.free - amt_q;
	assign top_e    = work_q[0];
	assign top_fit  = top_e.free >= amt_q;
	assign top_diff = top_e.free - amt_q;
	assign new_e    = '{dev: dev_q, free: amt_q};

	assign add_reject   = !bok_q || (n >= CW'(MAX_DEVICES));
	assign place_reject = !bok_q || (n == '0);
	assign sort_done    = idx_q == n_m1;
	assign pos_last     = CW'(pos_eff) == n_m1;

	// insertion: the new entry goes after the last entry it does not precede
	always_comb begin
		ins_pos = '0;
		for (int j = 0; j < MAX_DEVICES; j++) begin
			if ((CW'(j) < n) && !goes_before(new_e, work_q[j])) begin
				ins_pos = CW'(j + 1);
			end
		end
		ins_next[0] = (ins_pos == '0) ? new_e : work_q[0];
		for (int j = 1; j < MAX_DEVICES; j++) begin
			if (CW'(j) < ins_pos) begin
				ins_next[j] = work_q[j];
			end else if (CW'(j) == ins_pos) begin
				ins_next[j] = new_e;
			end else begin
				ins_next[j] = work_q[j-1];
			end
		end
	end

	// one odd-even transposition pass, phase from the pass count
	always_comb begin
		sort_next = work_q;
		for (int j = 0; j + 1 < MAX_DEVICES; j++) begin
			if ((1'(j) == idx_q[0]) && (CW'(j + 1) < n)
					&& goes_before(work_q[j+1], work_q[j])) begin
				sort_next[j]   = work_q[j+1];
				sort_next[j+1] = work_q[j];
			end
		end
	end

	// working list
	always_ff @(posedge clk) begin
		if (ctl.load_step) begin
			if (idx_q != '0) begin
				work_q[lane] <= rdata_q;
			end
		end else if (ctl.insert) begin
			work_q <= ins_next;
		end else if (ctl.try_place) begin
			if (fit) begin
				work_q[pos_eff].free <= sel_diff;
			end
		end else if (ctl.sort_step) begin
			work_q <= sort_next;
		end else if (ctl.top_place) begin
			if (top_fit) begin
				work_q[0].free <= top_diff;
			end
		end else if (ctl.write_step) begin
			for (int j = 0; j + 1 < MAX_DEVICES; j++) begin
				work_q[j] <= work_q[j+1];
			end
		end
	end

	// table memory, one address per cycle, registered read
	always_ff @(posedge clk) begin
		if (ctl.write_step) begin
			mem[maddr] <= work_q[0];
		end
		rdata_q <= mem[maddr];
	end

	// counts, positions and sequencing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '{default: '0};
			rot_q    <= '{default: '0};
			idx_q    <= '0;
			placed_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				placed_q <= 1'b0;
			end
			if (ctl.decode) begin
				idx_q <= '0;
				if (cmd_q == CMD_CLEAR) begin
					cnt_q <= '{default: '0};
					rot_q <= '{default: '0};
				end
			end
			if (ctl.load_step || ctl.write_step) begin
				idx_q <= idx_q + CW'(1);
			end
			if (ctl.insert) begin
				idx_q         <= '0;
				cnt_q[bidx_q] <= n + CW'(1);
			end
			if (ctl.try_place) begin
				idx_q <= '0;
				if (fit) begin
					placed_q      <= 1'b1;
					rot_q[bidx_q] <= pos_last ? '0 : PW'(pos_eff + PW'(1));
				end
			end
			if (ctl.sort_step) begin
				idx_q <= sort_done ? '0 : idx_q + CW'(1);
			end
			if (ctl.top_place && top_fit) begin
				rot_q[bidx_q] <= (n == CW'(1)) ? '0 : PW'(1);
			end
		end
	end

	// captured transaction and result fields
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q        <= req.cmd;
			bidx_q       <= bsel_wide[BW-1:0];
			bok_q        <= 32'(req.backend) < NUM_BACKENDS;
			dev_q        <= req.device_id;
			amt_q        <= amt_wide[MEM_BITS-1:0];
			job_q        <= req.job_id;
			res_status_q <= ST_OK;
			res_dev_q    <= '0;
			res_rem_q    <= '0;
		end
		if (ctl.decode) begin
			if ((cmd_q == CMD_ADD) && add_reject) begin
				res_status_q <= ST_FULL;
			end else if ((cmd_q == CMD_PLACE) && place_reject) begin
				res_status_q <= ST_NO_DEVICE;
			end
		end
		if (ctl.insert) begin
			len_q <= n + CW'(1);
		end
		if (ctl.try_place) begin
			len_q <= n;
			if (fit) begin
				res_dev_q <= sel.dev;
				res_rem_q <= sel_diff;
			end
		end
		if (ctl.top_place) begin
			if (top_fit) begin
				res_dev_q <= top_e.dev;
				res_rem_q <= top_diff;
			end else begin
				res_status_q <= ST_NO_MEMORY;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.respond) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.respond) begin
			out_q <= '{
				status:        res_status_q,
				placed_device: res_dev_q,
				placed_job:    job_q,
				remaining:     rem_wide[AMOUNT_W-1:0]
			};
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	// status to the controller
	assign sts.is_add       = cmd_q == CMD_ADD;
	assign sts.is_place     = cmd_q == CMD_PLACE;
	assign sts.add_reject   = add_reject;
	assign sts.place_reject = place_reject;
	assign sts.load_done    = idx_q == n;
	assign sts.sort_done    = sort_done;
	assign sts.write_done   = idx_q == len_m1;
	assign sts.fit          = fit;
	assign sts.pos_last     = pos_last;
	assign sts.placed       = placed_q;
	assign sts.out_free     = !out_valid_q || !rsp_stall;

endmodule

`default_nettype wire

// ===== src/dmp_ctrl.sv =====
// controller: sequences load, insert, place, sort and write-back per transaction
`default_nettype none

module dmp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dmp_pkg::dmp_sts_t sts,
	output dmp_pkg::dmp_ctl_t ctl
);
	import dmp_pkg::*;

	dmp_state_t state_q;
	dmp_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (sts.is_add && !sts.add_reject) begin
					state_d = S_LOAD;
				end else if (sts.is_place && !sts.place_reject) begin
					state_d = S_LOAD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_LOAD: begin
				if (sts.load_done) begin
					state_d = sts.is_add ? S_INSERT : S_TRY;
				end
			end
			S_INSERT: begin
				state_d = S_WRITE;
			end
			S_TRY: begin
				state_d = (sts.fit && !sts.pos_last) ? S_WRITE : S_SORT;
			end
			S_SORT: begin
				if (sts.sort_done) begin
					state_d = sts.placed ? S_WRITE : S_TOP;
				end
			end
			S_TOP: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (sts.write_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		ctl            = '0;
		ctl.capture    = (state_q == S_IDLE) && req_valid;
		ctl.decode     = state_q == S_DECODE;
		ctl.load_step  = state_q == S_LOAD;
		ctl.insert     = state_q == S_INSERT;
		ctl.try_place  = state_q == S_TRY;
		ctl.sort_step  = state_q == S_SORT;
		ctl.top_place  = state_q == S_TOP;
		ctl.write_step = state_q == S_WRITE;
		ctl.respond    = (state_q == S_RESP) && sts.out_free;
		req_stall      = state_q != S_IDLE;
	end

endmodule

`default_nettype wire

// ===== src/device_memory_placement_core.sv =====
// top level of the device memory placement core
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | dmp_pkg::req_t (cmd, backend, device, amount, job)
//   rsp     | out       | rsp_valid, rsp_stall | dmp_pkg::rsp_t (status, device, job, remaining)
//
// one request is worked at a time; n is the device count of the addressed list
// clear, unused code and rejected requests go straight from decode to the response
// add: load, insert and write-back; place: load, try, sort when needed, write-back
// the work time is set by the table memory, one entry per cycle in and out, and
// the odd-even sorter, one pass per cycle; counts and positions clear on reset
// a finished response waits in the output register, the next request is taken meanwhile
`default_nettype none

module device_memory_placement_core #(
	parameter int MAX_DEVICES  = dmp_pkg::MAX_DEVICES_DEF,
	parameter int NUM_BACKENDS = dmp_pkg::NUM_BACKENDS_DEF,
	parameter int MEM_BITS     = dmp_pkg::MEM_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dmp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dmp_pkg::rsp_t rsp
);
	import dmp_pkg::*;

	dmp_ctl_t ctl;
	dmp_sts_t sts;

	// sequencer
	dmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// table and arithmetic
	dmp_datapath #(
		.MAX_DEVICES  (MAX_DEVICES),
		.NUM_BACKENDS (NUM_BACKENDS),
		.MEM_BITS     (MEM_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== src/dmp_checker.sv =====
// port-level checks for the device memory placement core and their bind
`default_nettype none

module dmp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input dmp_pkg::rsp_t rsp
);
	import dmp_pkg::*;

	logic       req_acc;
	logic       rsp_acc;
	logic [1:0] pend_q;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	// transactions taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// the core is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("request taken while another is in work");

	// every response answers a request
	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a request");

	// at most one waiting response and one in work
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> req_stall)
		else $error("more than two transactions outstanding");

	// a failed command reports no device and no memory
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |->
			(rsp.placed_device == '0) && (rsp.remaining == '0))
		else $error("failed command reports a device");

endmodule

bind device_memory_placement_core dmp_checker u_dmp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
